[hw/rtl/tsc_pkg.sv]
// Shared types and constants for the temporal sample compositor.
package tsc_pkg;

	localparam int FRACTION_BITS_DEF = 15;
	localparam int CHANNELS = 4;
	localparam int PIXELS = 2;
	localparam int FIELD_W = 16;

	typedef enum logic [2:0] {
		MODE_ADD         = 3'd0,
		MODE_MAX         = 3'd1,
		MODE_MIN         = 3'd2,
		MODE_OVER_TOP    = 3'd3,
		MODE_OVER_BOTTOM = 3'd4
	} blend_mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREM,
		ST_FOLD,
		ST_DIV_START,
		ST_DIV_RUN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic       load;
		logic       prem;
		logic       fold;
		logic       first;
		logic [2:0] mode;
	} lane_ctrl_t;

	typedef struct packed {
		logic start;
		logic step;
	} div_ctrl_t;

endpackage

[hw/rtl/temporal_sample_compositor_unit.sv]
// Top level of the temporal sample compositor: sequencer, two pixel lanes, dividers, output.
//
// The block takes one sample beat at a time and folds its two RGBA pixels into a premultiplied
// accumulator with the blend mode in force when the beat is folded. A sample that does not
// close a run passes through capture with the alpha-opacity product, channel premultiply and
// fold; the next beat is taken on the cycle after the fold. A beat with tlast set then starts
// the dividers and runs bit-serial division (one quotient bit per cycle in six parallel
// dividers), then loads the output register, which may first wait on m_tready. The blend
// mode register may only be written while the block is idle.
module temporal_sample_compositor_unit import tsc_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wen,
	input  logic [2:0]   cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// p0_red, p0_green, p0_blue, p0_alpha, p1_red, p1_green, p1_blue, p1_alpha, sample_opacity
	input  logic [143:0] s_tdata,
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// q0_red, q0_green, q0_blue, q0_alpha, q1_red, q1_green, q1_blue, q1_alpha
	output logic [127:0] m_tdata
);

	localparam int VW = FRACTION_BITS + 1;
	localparam int CNTW = $clog2(FRACTION_BITS);

	state_t                                  state_q;
	state_t                                  state_d;
	logic [2:0]                              blend_mode_q;
	logic                                    first_q;
	logic                                    last_s1;
	logic [CNTW-1:0]                         cnt_q;
	logic                                    m_tvalid_q;
	logic [127:0]                            m_tdata_q;
	logic [127:0]                            out_d;
	logic                                    out_load;
	logic                                    accept;
	lane_ctrl_t                              lane_ctrl;
	div_ctrl_t                               div_ctrl;
	logic [PIXELS-1:0][CHANNELS-1:0][VW-1:0] acc;
	logic [PIXELS-1:0][2:0][VW-1:0]          quot;

	assign accept = s_tvalid && s_tready;

	for (genvar p = 0; p < PIXELS; p++) begin : g_pix
		tsc_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (lane_ctrl),
			.px      (s_tdata[p*64 +: 64]),
			.opacity (s_tdata[143:128]),
			.acc     (acc[p])
		);
		for (genvar c = 0; c < 3; c++) begin : g_ch
			tsc_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
				.clk    (clk),
				.arst_n (arst_n),
				.ctrl   (div_ctrl),
				.num    (acc[p][c]),
				.den    (acc[p][3]),
				.quot   (quot[p][c])
			);
		end
	end

	always_comb begin
		state_d         = state_q;
		s_tready        = 1'b0;
		out_load        = 1'b0;
		lane_ctrl.load  = 1'b0;
		lane_ctrl.prem  = 1'b0;
		lane_ctrl.fold  = 1'b0;
		lane_ctrl.first = first_q;
		lane_ctrl.mode  = blend_mode_q;
		div_ctrl.start  = 1'b0;
		div_ctrl.step   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready       = 1'b1;
				lane_ctrl.load = s_tvalid;
				if (s_tvalid) begin
					state_d = ST_PREM;
				end
			end
			ST_PREM: begin
				lane_ctrl.prem = 1'b1;
				state_d        = ST_FOLD;
			end
			ST_FOLD: begin
				lane_ctrl.fold = 1'b1;
				state_d        = last_s1 ? ST_DIV_START : ST_IDLE;
			end
			ST_DIV_START: begin
				div_ctrl.start = 1'b1;
				state_d        = ST_DIV_RUN;
			end
			ST_DIV_RUN: begin
				div_ctrl.step = 1'b1;
				if (cnt_q == CNTW'(FRACTION_BITS - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			blend_mode_q <= MODE_ADD;
			first_q      <= 1'b1;
			last_s1      <= 1'b0;
			cnt_q        <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wen) begin
				blend_mode_q <= cfg_wdata;
			end
			if (accept) begin
				last_s1 <= s_tlast;
			end
			if (lane_ctrl.fold) begin
				first_q <= last_s1;
			end
			if (div_ctrl.start) begin
				cnt_q <= '0;
			end else if (div_ctrl.step) begin
				cnt_q <= cnt_q + CNTW'(1);
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		for (int p = 0; p < PIXELS; p++) begin
			for (int c = 0; c < 3; c++) begin
				out_d[p*64 + c*16 +: 16] = 16'(quot[p][c]);
			end
			out_d[p*64 + 48 +: 16] = 16'(acc[p][3]);
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= out_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_DONE))
		else $error("Output beat appeared without a finished division.");

	a_last_reaches_div: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tlast) |-> ##3 (state_q == ST_DIV_START))
		else $error("A closing sample beat did not start the dividers on time.");

	a_run_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_START) |-> first_q)
		else $error("Run was not closed before unpremultiplying.");

endmodule

[hw/rtl/tsc_lane.sv]
// One pixel lane: premultiply by opacity and fold into the premultiplied accumulator.
module tsc_lane import tsc_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF,
	localparam int VW = FRACTION_BITS + 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lane_ctrl_t                      ctrl,
	input  logic [CHANNELS-1:0][FIELD_W-1:0] px,
	input  logic [FIELD_W-1:0]              opacity,
	output logic [CHANNELS-1:0][VW-1:0]     acc
);

	localparam int PW = VW + FIELD_W;
	localparam int MW = 2 * VW;
	localparam int SW = VW + 1;
	localparam logic [VW-1:0] ONE = VW'(1) << FRACTION_BITS;

	function automatic logic [VW-1:0] sat_in(input logic [FIELD_W-1:0] v);
		logic [PW-1:0] e;
		e = PW'(v);
		return (e > PW'(ONE)) ? ONE : e[VW-1:0];
	endfunction

	function automatic logic [VW-1:0] sat_sum(input logic [SW-1:0] v);
		return (v > SW'(ONE)) ? ONE : v[VW-1:0];
	endfunction

	logic [2:0][VW-1:0]          c_s1;
	logic [VW-1:0]               a_s1;
	logic [CHANNELS-1:0][VW-1:0] nw_s2;
	logic [CHANNELS-1:0][VW-1:0] acc_q;
	logic [CHANNELS-1:0][VW-1:0] fold_r;
	logic [PW-1:0]               a_prod;
	logic [PW-1:0]               a_shift;
	logic [VW-1:0]               a_new;
	logic [2:0][MW-1:0]          pm;

	always_comb begin
		a_prod  = PW'(sat_in(px[3])) * PW'(opacity);
		a_shift = a_prod >> FRACTION_BITS;
		a_new   = (a_shift > PW'(ONE)) ? ONE : a_shift[VW-1:0];
		for (int i = 0; i < 3; i++) begin
			pm[i] = (MW'(c_s1[i]) * MW'(a_s1)) >> FRACTION_BITS;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			for (int i = 0; i < 3; i++) begin
				c_s1[i] <= sat_in(px[i]);
			end
			a_s1 <= a_new;
		end
		if (ctrl.prem) begin
			for (int i = 0; i < 3; i++) begin
				nw_s2[i] <= pm[i][VW-1:0];
			end
			nw_s2[3] <= a_s1;
		end
	end

	always_comb begin
		logic          bottom;
		logic [VW-1:0] mx;
		logic [VW-1:0] my;
		logic [VW-1:0] base;
		logic [MW-1:0] fm;
		logic [SW-1:0] sadd;
		logic [SW-1:0] sov;
		bottom = (ctrl.mode == MODE_OVER_BOTTOM);
		for (int i = 0; i < CHANNELS; i++) begin
			mx   = bottom ? nw_s2[i] : acc_q[i];
			my   = bottom ? (ONE - acc_q[3]) : (ONE - nw_s2[3]);
			base = bottom ? acc_q[i] : nw_s2[i];
			fm   = (MW'(mx) * MW'(my)) >> FRACTION_BITS;
			sadd = SW'(acc_q[i]) + SW'(nw_s2[i]);
			sov  = SW'(base) + SW'(fm[VW-1:0]);
			case (ctrl.mode)
				MODE_ADD: fold_r[i] = sat_sum(sadd);
				MODE_MAX: fold_r[i] = (acc_q[i] > nw_s2[i]) ? acc_q[i] : nw_s2[i];
				MODE_MIN: fold_r[i] = (acc_q[i] < nw_s2[i]) ? acc_q[i] : nw_s2[i];
				default:  fold_r[i] = sat_sum(sov);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.fold) begin
			acc_q <= ctrl.first ? nw_s2 : fold_r;
		end
	end

	assign acc = acc_q;

endmodule

[hw/rtl/tsc_div.sv]
// Bit-serial restoring divider for unpremultiplying one channel, clamped to one.
module tsc_div import tsc_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF,
	localparam int VW = FRACTION_BITS + 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  div_ctrl_t     ctrl,
	input  logic [VW-1:0] num,
	input  logic [VW-1:0] den,
	output logic [VW-1:0] quot
);

	localparam logic [VW-1:0] ONE = VW'(1) << FRACTION_BITS;

	logic [VW-1:0] rem_q;
	logic [VW-1:0] quot_q;
	logic          run_q;
	logic [VW:0]   r2;
	logic          ge;

	assign r2 = {rem_q, 1'b0};
	assign ge = (r2 >= {1'b0, den});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else if (ctrl.start) begin
			run_q <= (den != '0) && (num < den);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			rem_q <= num;
			if (den == '0) begin
				quot_q <= '0;
			end else if (num >= den) begin
				quot_q <= ONE;
			end else begin
				quot_q <= '0;
			end
		end else if (ctrl.step && run_q) begin
			rem_q  <= ge ? VW'(r2 - {1'b0, den}) : r2[VW-1:0];
			quot_q <= {quot_q[VW-2:0], ge};
		end
	end

	assign quot = quot_q;

endmodule

[test/tb_top.sv]
// Self-checking testbench for the temporal sample compositor with directed and random sample runs.
module tb_top import tsc_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = FRACTION_BITS_DEF;
	localparam logic [31:0] UNIT = 32'd1 << FB;
	localparam int SETTLE_CYCLES = FB + 10;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_SAMPLES = 170;
	localparam int PRESSURE_SAMPLES = 40;

	localparam logic [2:0] MODE_SPARE_5 = 3'd5;
	localparam logic [2:0] MODE_SPARE_6 = 3'd6;
	localparam logic [2:0] MODE_SPARE_7 = 3'd7;

	typedef logic [7:0][15:0] chan_set_t;

	typedef struct packed {
		logic [2:0]  mode;
		chan_set_t   px;
		logic [15:0] opacity;
		logic        last;
		logic        known;
		chan_set_t   want;
	} sample_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_wen = 1'b0;
	logic [2:0]   cfg_wdata = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [143:0] s_tdata = '0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;

	chan_set_t    accum = '0;
	bit           run_fresh = 1'b1;
	logic [2:0]   cur_mode = MODE_ADD;
	chan_set_t    pending_pixels[$];
	sample_row_t  directed[$];

	int           errors = 0;
	int           cycles = 0;
	int           samples_sent = 0;
	int           results_seen = 0;
	logic [7:0]   modes_used = '0;
	int           send_idle_pct = 0;
	int           stall_pct = 0;
	int           hold_req = 0;
	int           hold_seen = 0;
	int           hold_left = 0;

	string        field_names[8] = '{"q0_red", "q0_green", "q0_blue", "q0_alpha",
		"q1_red", "q1_green", "q1_blue", "q1_alpha"};

	temporal_sample_compositor_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] to_unit(logic [31:0] v);
		return (v > UNIT) ? UNIT : v;
	endfunction

	function automatic logic [31:0] fx_mul(logic [31:0] a, logic [31:0] b);
		return (a * b) >> FB;
	endfunction

	function automatic logic [63:0] rgba(logic [15:0] r, logic [15:0] g, logic [15:0] b,
		logic [15:0] a);
		return {a, b, g, r};
	endfunction

	function automatic sample_row_t step_row(logic [2:0] m, logic [63:0] p0, logic [63:0] p1,
		logic [15:0] op, logic lst);
		return '{mode: m, px: {p1, p0}, opacity: op, last: lst, known: 1'b0, want: '0};
	endfunction

	function automatic sample_row_t known_row(logic [2:0] m, logic [63:0] p0, logic [63:0] p1,
		logic [15:0] op, logic [63:0] w0, logic [63:0] w1);
		return '{mode: m, px: {p1, p0}, opacity: op, last: 1'b1, known: 1'b1, want: {w1, w0}};
	endfunction

	// Premultiplies both pixels, folds them into the accumulator and, on the closing sample,
	// returns the straight-alpha composition.
	function automatic void compose_sample(input chan_set_t px, input logic [15:0] op,
		input logic lst, input logic [2:0] mode, output bit emits, output chan_set_t res);
		chan_set_t   fresh;
		logic [31:0] a;
		logic [31:0] na;
		logic [31:0] aa;
		logic [31:0] r;
		int          b;
		res = '0;
		for (int p = 0; p < 2; p++) begin
			b = 4 * p;
			a = to_unit(fx_mul(to_unit(32'(px[b + 3])), 32'(op)));
			for (int i = 0; i < 3; i++)
				fresh[b + i] = 16'(fx_mul(to_unit(32'(px[b + i])), a));
			fresh[b + 3] = 16'(a);
		end
		if (run_fresh) begin
			accum = fresh;
		end else begin
			for (int p = 0; p < 2; p++) begin
				b = 4 * p;
				na = 32'(fresh[b + 3]);
				aa = 32'(accum[b + 3]);
				for (int i = 0; i < 4; i++) begin
					case (mode)
						MODE_ADD: r = to_unit(32'(accum[b + i]) + 32'(fresh[b + i]));
						MODE_MAX: r = (accum[b + i] > fresh[b + i]) ? 32'(accum[b + i]) :
							32'(fresh[b + i]);
						MODE_MIN: r = (accum[b + i] < fresh[b + i]) ? 32'(accum[b + i]) :
							32'(fresh[b + i]);
						MODE_OVER_BOTTOM:
							r = to_unit(32'(accum[b + i]) + fx_mul(32'(fresh[b + i]), UNIT - aa));
						default:
							r = to_unit(32'(fresh[b + i]) + fx_mul(32'(accum[b + i]), UNIT - na));
					endcase
					accum[b + i] = 16'(r);
				end
			end
		end
		run_fresh = lst;
		emits = lst;
		if (lst) begin
			for (int p = 0; p < 2; p++) begin
				b = 4 * p;
				a = to_unit(32'(accum[b + 3]));
				for (int i = 0; i < 3; i++)
					res[b + i] = (a == 0) ? 16'd0 : 16'(to_unit((32'(accum[b + i]) << FB) / a));
				res[b + 3] = 16'(a);
			end
		end
	endfunction

	function automatic logic [15:0] random_channel();
		case ($urandom_range(9))
			0: return 16'd0;
			1: return 16'(UNIT);
			2: return 16'hFFFF;
			3, 4: return 16'($urandom_range(16'hFFFF));
			default: return 16'($urandom_range(UNIT));
		endcase
	endfunction

	function automatic logic [15:0] random_opacity();
		case ($urandom_range(7))
			0: return 16'd0;
			1: return 16'(UNIT);
			2: return 16'hFFFF;
			3: return 16'($urandom_range(16'hFFFF));
			default: return 16'($urandom_range(UNIT));
		endcase
	endfunction

	task automatic report_error(string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		errors++;
	endtask

	task automatic send_sample(chan_set_t px, logic [15:0] op, logic lst, logic known,
		chan_set_t want);
		chan_set_t got;
		bit        emits;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {op, px};
		s_tlast <= lst;
		do
			@(posedge clk);
		while (!s_tready);
		compose_sample(px, op, lst, cur_mode, emits, got);
		if (emits)
			pending_pixels.push_back(known ? want : got);
		samples_sent++;
	endtask

	task automatic send_random_sample(logic lst);
		chan_set_t px;
		for (int i = 0; i < 8; i++)
			px[i] = random_channel();
		send_sample(px, random_opacity(), lst, 1'b0, '0);
	endtask

	// The block may still be folding a sample that closes no run, so wait out its latency too.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(logic [2:0] m);
		cfg_wen <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_wen <= 1'b0;
		cur_mode = m;
		modes_used[m] = 1'b1;
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results pending", cycles,
				pending_pixels.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		chan_set_t got;
		chan_set_t want;
		string     diffs;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			got = m_tdata;
			if (pending_pixels.size() == 0) begin
				report_error($sformatf("result %h arrived with nothing pending", got));
			end else begin
				want = pending_pixels.pop_front();
				diffs = "";
				for (int i = 0; i < 8; i++)
					if (got[i] !== want[i])
						diffs = {diffs, $sformatf(" %s=%0d/%0d", field_names[i], got[i], want[i])};
				if (diffs != "")
					report_error($sformatf("result %0d differs (got/expected):%s", results_seen,
						diffs));
			end
		end
	end

	initial begin
		sample_row_t row;
		int          len;
		int          sent;
		logic [2:0]  phase_mode[4];
		int          phase_idle[4];
		int          phase_stall[4];
		phase_mode = '{MODE_SPARE_6, MODE_ADD, MODE_OVER_BOTTOM, MODE_SPARE_7};
		phase_idle = '{0, 59, 0, 10};
		phase_stall = '{0, 0, 59, 10};

		directed.push_back(known_row(MODE_ADD, rgba(32768, 32768, 32768, 32768),
			rgba(32768, 32768, 32768, 32768), 16'd32768,
			rgba(32768, 32768, 32768, 32768), rgba(32768, 32768, 32768, 32768)));
		directed.push_back(known_row(MODE_ADD, rgba(0, 0, 0, 0), rgba(0, 0, 0, 0), 16'd0,
			rgba(0, 0, 0, 0), rgba(0, 0, 0, 0)));
		directed.push_back(known_row(MODE_ADD, rgba(65535, 65535, 65535, 65535),
			rgba(65535, 65535, 65535, 65535), 16'd32768,
			rgba(32768, 32768, 32768, 32768), rgba(32768, 32768, 32768, 32768)));
		directed.push_back(known_row(MODE_ADD, rgba(16384, 16384, 16384, 32768),
			rgba(32768, 32768, 32768, 16384), 16'd65535,
			rgba(16384, 16384, 16384, 32768), rgba(32768, 32768, 32768, 32767)));
		directed.push_back(known_row(MODE_ADD, rgba(30000, 30000, 30000, 0),
			rgba(12345, 12345, 12345, 1), 16'd32768, rgba(0, 0, 0, 0), rgba(0, 0, 0, 1)));
		directed.push_back(step_row(MODE_ADD, rgba(10000, 20000, 30000, 16384),
			rgba(5000, 32768, 0, 24576), 16'd32768, 1'b0));
		directed.push_back(step_row(MODE_ADD, rgba(30000, 1000, 12000, 20000),
			rgba(32768, 32768, 32768, 32768), 16'd16384, 1'b1));
		directed.push_back(step_row(MODE_MAX, rgba(32768, 0, 16000, 8192),
			rgba(100, 200, 300, 32768), 16'd32768, 1'b0));
		directed.push_back(step_row(MODE_MAX, rgba(0, 32768, 8000, 32768),
			rgba(65535, 0, 40000, 12000), 16'd49152, 1'b1));
		directed.push_back(step_row(MODE_MIN, rgba(20000, 20000, 20000, 32768),
			rgba(1, 2, 3, 4), 16'd32768, 1'b0));
		directed.push_back(step_row(MODE_MIN, rgba(25000, 100, 32768, 16384),
			rgba(32768, 32768, 32768, 32768), 16'd65535, 1'b1));
		directed.push_back(step_row(MODE_OVER_TOP, rgba(32768, 0, 0, 32768),
			rgba(0, 32768, 0, 16384), 16'd32768, 1'b0));
		directed.push_back(step_row(MODE_OVER_TOP, rgba(0, 32768, 0, 16384),
			rgba(0, 0, 32768, 8192), 16'd32768, 1'b0));
		directed.push_back(step_row(MODE_OVER_TOP, rgba(0, 0, 32768, 8192),
			rgba(32768, 32768, 0, 32768), 16'd20000, 1'b1));
		directed.push_back(step_row(MODE_OVER_BOTTOM, rgba(32768, 32768, 0, 12000),
			rgba(1000, 2000, 3000, 0), 16'd32768, 1'b0));
		directed.push_back(step_row(MODE_OVER_BOTTOM, rgba(0, 16384, 32768, 32768),
			rgba(32768, 0, 0, 32768), 16'd32768, 1'b1));
		directed.push_back(step_row(MODE_SPARE_5, rgba(32768, 0, 0, 16384),
			rgba(7, 7, 7, 7), 16'd65535, 1'b0));
		directed.push_back(step_row(MODE_SPARE_5, rgba(0, 32768, 0, 16384),
			rgba(9, 9, 9, 32768), 16'd32768, 1'b1));
		directed.push_back(step_row(MODE_SPARE_7, rgba(4000, 8000, 12000, 30000),
			rgba(32768, 1, 32768, 20000), 16'd40000, 1'b0));
		directed.push_back(step_row(MODE_SPARE_7, rgba(32768, 32768, 32768, 1000),
			rgba(0, 0, 0, 32768), 16'd32768, 1'b1));
		directed.push_back(step_row(MODE_ADD, rgba(12000, 24000, 32768, 10000),
			rgba(500, 600, 700, 32768), 16'd32768, 1'b0));
		directed.push_back(step_row(MODE_OVER_TOP, rgba(32768, 0, 32768, 20000),
			rgba(32768, 32768, 0, 4000), 16'd30000, 1'b0));
		directed.push_back(step_row(MODE_OVER_BOTTOM, rgba(100, 32768, 900, 32768),
			rgba(0, 16000, 32768, 16384), 16'd32768, 1'b1));
		directed.push_back(step_row(MODE_MIN, rgba(12345, 54321, 32767, 32769),
			rgba(1, 32768, 65535, 2), 16'd33000, 1'b1));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			row = directed[i];
			if (row.mode != cur_mode) begin
				settle();
				write_mode(row.mode);
			end
			send_sample(row.px, row.opacity, row.last, row.known, row.want);
		end

		for (int phase = 0; phase < 4; phase++) begin
			settle();
			send_idle_pct = phase_idle[phase];
			stall_pct = phase_stall[phase];
			write_mode(phase_mode[phase]);
			if (phase == 0) begin
				// Hold the output side off while single-sample runs keep arriving.
				hold_req <= hold_req + 1;
				repeat (PRESSURE_SAMPLES) send_random_sample(1'b1);
			end
			sent = 0;
			while (sent < PHASE_SAMPLES) begin
				if ($urandom_range(5) == 0) begin
					settle();
					write_mode(3'($urandom_range(7)));
				end
				len = ($urandom_range(4) == 0) ? $urandom_range(20, 5) : $urandom_range(4, 1);
				for (int k = 0; k < len; k++) begin
					if (k > 0 && $urandom_range(19) == 0) begin
						settle();
						write_mode(3'($urandom_range(7)));
					end
					send_random_sample(k == len - 1);
				end
				sent += len;
			end
		end

		settle();
		$display("Run covered %0d sample beats and %0d composed results over four handshake phases,",
			samples_sent, results_seen);
		$display("with blend codes %b written and a long output hold-off; %0d mismatches.",
			modes_used, errors);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
